>>> rtl/sgs_pkg.sv
// Shared types, codes and defaults for the swing gate sequencer.
package sgs_pkg;

    localparam int unsigned DWELL_BITS_DEFAULT = 16;
    localparam int unsigned DWELL_TICKS_WIDTH = 16;
    localparam logic [DWELL_TICKS_WIDTH-1:0] DWELL_TICKS_RESET = 16'd1000;

    typedef enum logic [1:0] {
        PH_OPEN  = 2'd0,
        PH_WAIT  = 2'd1,
        PH_CLOSE = 2'd2,
        PH_STOP  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        MOT_STOP  = 2'd0,
        MOT_OPEN  = 2'd1,
        MOT_CLOSE = 2'd2
    } motor_t;

    typedef enum logic [2:0] {
        DISP_IDLE     = 3'd0,
        DISP_A        = 3'd1,
        DISP_B        = 3'd2,
        DISP_BOTH     = 3'd3,
        DISP_NO_ENTRY = 3'd4,
        DISP_A_ACTIVE = 3'd5,
        DISP_B_ACTIVE = 3'd6,
        DISP_OBSTRUCT = 3'd7
    } disp_t;

    typedef enum logic [1:0] {
        FLT_NONE   = 2'd0,
        FLT_SIDE_A = 2'd1,
        FLT_SIDE_B = 2'd2
    } fault_t;

    typedef struct packed {
        logic       entry_req_a;
        logic       entry_req_b;
        logic [2:0] mode_switches;
        logic [4:0] beams;
        logic [3:0] limits;
    } item_t;

    typedef struct packed {
        logic [1:0] motor_command;
        logic [2:0] display_mode;
        logic [1:0] fault_event;
    } result_t;

endpackage

>>> rtl/swing_gate_sequencer.sv
// Top level of the swing gate sequencer: handshakes, dwell register, result register.
//
//   Channel   Direction  Handshake                    Payload
//   item      in         item_valid / item_ready      sgs_pkg::item_t (one control tick)
//   result    out        result_valid / result_ready  sgs_pkg::result_t (one per tick)
//   cfg       in         cfg_valid / cfg_ready        cfg_data, the dwell_ticks register
//
// Every accepted tick transaction produces exactly one result transaction.
// A tick is decided in the cycle it is accepted and its result appears in
// the result register on the next cycle, so one tick per cycle is sustained while results drain.
// The throughput is set only by the single result register: a new tick is
// taken whenever that register is empty or is being drained in the same cycle.
// Reset is asynchronous and active low; it loads the dwell register with 1000
// and puts the gate in the open phase with the motor commanded to open.
// A stalled result holds the input side off; configuration writes are always taken.
module swing_gate_sequencer #(
    parameter int unsigned DWELL_BITS = sgs_pkg::DWELL_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  sgs_pkg::item_t                        item,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output sgs_pkg::result_t                      result,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sgs_pkg::DWELL_TICKS_WIDTH-1:0] cfg_data
);

    logic [sgs_pkg::DWELL_TICKS_WIDTH-1:0] dwell_reg;
    logic                                  result_valid_reg;
    sgs_pkg::result_t                      result_reg;
    sgs_pkg::result_t                      tick_result;
    logic                                  item_take;

    // The dwell register can be written in any cycle.
    assign cfg_ready = 1'b1;

    // A tick is accepted when the result register is free or being emptied now.
    assign item_ready = !result_valid_reg || result_ready;
    assign item_take  = item_valid && item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dwell_reg <= sgs_pkg::DWELL_TICKS_RESET;
        else if (cfg_valid && cfg_ready)
            dwell_reg <= cfg_data;
    end

    // The core updates its state on every accepted tick and presents the
    // tick's outcome combinationally for capture in the result register.
    sgs_core #(
        .DWELL_BITS (DWELL_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (item_take),
        .item        (item),
        .dwell_ticks (dwell_reg),
        .result      (tick_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (item_take)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    // The payload register needs no reset; it is qualified by the valid flag.
    always_ff @(posedge clk)
    begin
        if (item_take)
            result_reg <= tick_result;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTH
    // Every accepted tick must show up as a pending result on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> result_valid)
        else $error("accepted tick produced no result");

    // The motor command is always one of the three defined commands.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.motor_command == sgs_pkg::MOT_STOP ||
                          result.motor_command == sgs_pkg::MOT_OPEN ||
                          result.motor_command == sgs_pkg::MOT_CLOSE))
        else $error("undefined motor command");

    // A fault pulse always carries one of the two defined side codes.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.fault_event != sgs_pkg::FLT_NONE |->
            (result.fault_event == sgs_pkg::FLT_SIDE_A ||
             result.fault_event == sgs_pkg::FLT_SIDE_B))
        else $error("undefined fault code");
`endif

endmodule

>>> rtl/sgs_core.sv
// Gate sequencer state and the per-tick decision logic.
module sgs_core #(
    parameter int unsigned DWELL_BITS = sgs_pkg::DWELL_BITS_DEFAULT
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       step,
    input  sgs_pkg::item_t                             item,
    input  logic [sgs_pkg::DWELL_TICKS_WIDTH-1:0]      dwell_ticks,
    output sgs_pkg::result_t                           result
);

    localparam int unsigned CMP_W = (DWELL_BITS > sgs_pkg::DWELL_TICKS_WIDTH) ?
                                    DWELL_BITS : sgs_pkg::DWELL_TICKS_WIDTH;
    localparam logic [CMP_W-1:0] CNT_MAX = CMP_W'((64'd1 << DWELL_BITS) - 64'd1);

    sgs_pkg::phase_t       phase_reg, phase_next;
    sgs_pkg::motor_t       motor_reg, motor_next;
    sgs_pkg::disp_t        shown_reg, shown_next;
    sgs_pkg::fault_t       fault_code;
    logic                  lock_reg, lock_next;
    logic                  side_reg, side_next;
    logic                  pend_a_reg, pend_a_next;
    logic                  pend_b_reg, pend_b_next;
    logic [DWELL_BITS-1:0] cnt_reg, cnt_next;

    logic             obstruct;
    logic             a_ext;
    logic             b_ext;
    logic [CMP_W-1:0] dwell_ext;
    logic [CMP_W-1:0] dwell_limit;

    assign a_ext    = item.beams[0];
    assign b_ext    = item.beams[4];
    assign obstruct = !item.beams[1] || !item.beams[2] || !item.beams[3];

    // The limit is clamped to the counter range so the counter never wraps.
    assign dwell_ext   = CMP_W'(dwell_ticks);
    assign dwell_limit = (dwell_ext > CNT_MAX) ? CNT_MAX : dwell_ext;

    always_comb
    begin
        phase_next  = phase_reg;
        motor_next  = motor_reg;
        shown_next  = shown_reg;
        lock_next   = lock_reg;
        side_next   = side_reg;
        pend_a_next = pend_a_reg || item.entry_req_a;
        pend_b_next = pend_b_reg || item.entry_req_b;
        cnt_next    = cnt_reg;
        fault_code  = sgs_pkg::FLT_NONE;

        if (phase_reg == sgs_pkg::PH_WAIT)
        begin
            if (!obstruct)
            begin
                motor_next = sgs_pkg::MOT_CLOSE;
                phase_next = sgs_pkg::PH_CLOSE;
            end
        end
        else
        begin
            if (item.mode_switches[0])
                shown_next = sgs_pkg::DISP_A;
            if (item.mode_switches[1])
                shown_next = sgs_pkg::DISP_B;
            if (item.mode_switches[2])
                shown_next = sgs_pkg::DISP_BOTH;
            if (item.mode_switches == 3'b000)
            begin
                pend_a_next = 1'b0;
                pend_b_next = 1'b0;
                shown_next  = sgs_pkg::DISP_NO_ENTRY;
            end
            if (obstruct)
            begin
                pend_a_next = 1'b0;
                pend_b_next = 1'b0;
                shown_next  = sgs_pkg::DISP_OBSTRUCT;
            end

            // Side A request; its far beam is B external.
            if (pend_a_next && (item.mode_switches[0] || item.mode_switches[2]) && !obstruct)
            begin
                pend_a_next = 1'b0;
                if (!lock_next)
                begin
                    lock_next = (phase_next != sgs_pkg::PH_STOP);
                    if (!b_ext)
                        fault_code = sgs_pkg::FLT_SIDE_A;
                    else
                    begin
                        cnt_next   = '0;
                        motor_next = sgs_pkg::MOT_OPEN;
                        phase_next = sgs_pkg::PH_OPEN;
                        side_next  = 1'b0;
                    end
                end
            end

            // Side B request; a side A fault in the same tick takes precedence.
            if (pend_b_next && (item.mode_switches[1] || item.mode_switches[2]) && !obstruct)
            begin
                pend_b_next = 1'b0;
                if (!lock_next)
                begin
                    lock_next = (phase_next != sgs_pkg::PH_STOP);
                    if (!a_ext)
                    begin
                        if (fault_code == sgs_pkg::FLT_NONE)
                            fault_code = sgs_pkg::FLT_SIDE_B;
                    end
                    else
                    begin
                        cnt_next   = '0;
                        motor_next = sgs_pkg::MOT_OPEN;
                        phase_next = sgs_pkg::PH_OPEN;
                        side_next  = 1'b1;
                    end
                end
            end

            if (phase_next == sgs_pkg::PH_OPEN && item.limits[0] && item.limits[1])
            begin
                motor_next = sgs_pkg::MOT_STOP;
                shown_next = side_next ? sgs_pkg::DISP_B_ACTIVE : sgs_pkg::DISP_A_ACTIVE;
                if (CMP_W'(cnt_next) < dwell_limit)
                begin
                    cnt_next = cnt_next + DWELL_BITS'(1);
                    if (side_next ? !a_ext : !b_ext)
                    begin
                        if (obstruct)
                            phase_next = sgs_pkg::PH_WAIT;
                        else
                        begin
                            motor_next = sgs_pkg::MOT_CLOSE;
                            phase_next = sgs_pkg::PH_CLOSE;
                        end
                    end
                end
                else
                begin
                    motor_next = sgs_pkg::MOT_CLOSE;
                    phase_next = sgs_pkg::PH_CLOSE;
                end
            end
        end

        // Close and stop checks; they do nothing while the phase is still wait.
        if (phase_next == sgs_pkg::PH_CLOSE)
        begin
            if (item.limits[2] && item.limits[3])
            begin
                lock_next  = 1'b0;
                motor_next = sgs_pkg::MOT_STOP;
                phase_next = sgs_pkg::PH_STOP;
            end
            if (obstruct && !item.limits[0] && !item.limits[1])
            begin
                cnt_next   = '0;
                motor_next = sgs_pkg::MOT_OPEN;
                phase_next = sgs_pkg::PH_OPEN;
            end
        end
        if (phase_next == sgs_pkg::PH_STOP)
        begin
            if (!item.limits[2] && !item.limits[3])
            begin
                motor_next = sgs_pkg::MOT_CLOSE;
                phase_next = sgs_pkg::PH_CLOSE;
            end
        end

        result.motor_command = motor_next;
        result.display_mode  = shown_next;
        result.fault_event   = fault_code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= sgs_pkg::PH_OPEN;
            motor_reg  <= sgs_pkg::MOT_OPEN;
            shown_reg  <= sgs_pkg::DISP_IDLE;
            lock_reg   <= 1'b0;
            side_reg   <= 1'b0;
            pend_a_reg <= 1'b0;
            pend_b_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            motor_reg  <= motor_next;
            shown_reg  <= shown_next;
            lock_reg   <= lock_next;
            side_reg   <= side_next;
            pend_a_reg <= pend_a_next;
            pend_b_reg <= pend_b_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule
